// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the reel controller link
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RCNL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RCNL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rcnl_pkg.sv =====
// ----------------------------------------------------------------------------
// rcnl_pkg
// types and constants of the reel controller nibble link
// ----------------------------------------------------------------------------
package rcnl_pkg;

   localparam int REQ_W     = 40;
   localparam int RSP_W     = 32;
   localparam int DATA_W    = 8;
   localparam int NIB_W     = 4;
   localparam int POS_W     = 7;
   localparam int HALF_W    = 6;
   localparam int STEP_W    = 13;
   localparam int TGT_W     = 15;
   localparam int RX_DEPTH  = 17;
   localparam int RX_AW     = 5;
   localparam int TX_DEPTH  = 7;
   localparam int TX_AW     = 3;
   localparam int CNT_W     = 6;
   localparam int LEFT_W    = 5;
   localparam int TXL_W     = 4;
   localparam int REEL_W    = 2;
   localparam int NUM_POS   = 4;

   localparam logic [CNT_W-1:0] MAX_NIBBLES = CNT_W'(2 * RX_DEPTH);

   localparam logic [NIB_W-1:0]  CMD_SPIN = 4'h1;
   localparam logic [NIB_W-1:0]  CMD_POS  = 4'h4;
   localparam logic [NIB_W-1:0]  CMD_GOTO = 4'h8;
   localparam logic [NIB_W-1:0]  CMD_BUSY = 4'h9;
   localparam logic [NIB_W-1:0]  CMD_ID   = 4'hf;
   localparam logic [DATA_W-1:0] ID_BYTE      = 8'hf1;
   localparam logic [DATA_W-1:0] VERSION_BYTE = 8'h10;
   localparam logic [DATA_W-1:0] ZERO_SUM     = 8'hff;
   localparam logic [DATA_W-1:0] POS_BIAS     = 8'd3;

   localparam logic [TXL_W-1:0] NIB_SHORT  = 4'd8;
   localparam logic [TXL_W-1:0] NIB_LONG   = 4'd14;
   localparam logic [NIB_W-1:0] PLEN_SHORT = 4'd1;
   localparam logic [NIB_W-1:0] PLEN_LONG  = 4'd4;
   localparam logic [TX_AW-1:0] END_SHORT  = 3'd3;
   localparam logic [TX_AW-1:0] END_LONG   = 3'd6;

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAT_NONE = 2'd0,
      STAT_OK   = 2'd1,
      STAT_BAD  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SUM,
      S_RD0,
      S_RD1,
      S_BUILD,
      S_TXSUM,
      S_MVHI,
      S_MVLO,
      S_MODT,
      S_MODA,
      S_MVOUT,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      logic                en;
      logic                hi;
      logic [RX_AW-1:0]    addr;
      logic [NIB_W-1:0]    nib;
   } rx_wr_type;

endpackage

// ===== rtl/rcnl_rx_buf.sv =====
// ----------------------------------------------------------------------------
// rcnl_rx_buf
// receive frame buffer, nibble write port and one byte read port
// ----------------------------------------------------------------------------
module rcnl_rx_buf (
   input  logic                                clock,
   input  logic                                reset,
   input  rcnl_pkg::rx_wr_type                 wr,
   input  logic [rcnl_pkg::RX_AW-1:0]          rd_addr,
   output logic [rcnl_pkg::DATA_W-1:0]         rd_data
);
   import rcnl_pkg::*;

   logic [NIB_W-1:0] lo_ff [RX_DEPTH];
   logic [NIB_W-1:0] hi_ff [RX_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RX_DEPTH; i++) begin
            lo_ff[i] <= '0;
            hi_ff[i] <= '0;
         end
      end else if (wr.en) begin
         if (wr.hi) begin
            hi_ff[wr.addr] <= wr.nib;
         end else begin
            lo_ff[wr.addr] <= wr.nib;
            hi_ff[wr.addr] <= '0;
         end
      end
   end

   always_comb begin
      if (rd_addr < RX_AW'(RX_DEPTH)) begin
         rd_data = {hi_ff[rd_addr], lo_ff[rd_addr]};
      end else begin
         rd_data = '0;
      end
   end

endmodule

// ===== rtl/rcnl_mod_unit.sv =====
// ----------------------------------------------------------------------------
// rcnl_mod_unit
// remainder by a fixed divisor through a reciprocal multiply
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcnl_mod_unit #(
   parameter int  DIVISOR = 48,
   localparam int MW      = $clog2(DIVISOR)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rcnl_pkg::TGT_W-1:0]      value,
   output logic                            done,
   output logic [MW-1:0]                   rem
);
   import rcnl_pkg::*;

   localparam int             SHIFT   = TGT_W + MW;
   localparam int             KW      = TGT_W + 2;
   localparam int             PW      = TGT_W + KW;
   localparam int             QW      = PW - SHIFT;
   localparam longint         RECIP_L =
      ((longint'(1) <<< SHIFT) + longint'(DIVISOR - 1)) / longint'(DIVISOR);
   localparam logic [KW-1:0]  RECIP   = KW'(RECIP_L);

   logic              step_ff;
   logic              done_ff;
   logic [TGT_W-1:0]  val_ff;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [MW-1:0]     rem_ff, rem_in;
   logic [PW-1:0]     prod;
   logic [TGT_W-1:0]  back;

   // quotient estimate, exact for every dividend below 2**TGT_W
   always_comb begin
      prod   = PW'(value) * PW'(RECIP);
      quo_in = prod[PW-1:SHIFT];
      back   = TGT_W'(quo_ff) * TGT_W'(DIVISOR);
      rem_in = MW'(val_ff - back);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= start;
         done_ff <= step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff <= value;
         quo_ff <= quo_in;
      end
      if (step_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

   `RCNL_ASSERT_IMPL(a_rem_range, clock, reset, done_ff, rem_ff < MW'(DIVISOR - 1) || rem_ff == MW'(DIVISOR - 1), "remainder not below divisor")
   `RCNL_ASSERT_NEXT(a_step_done, clock, reset, step_ff, done_ff, "remainder late")
   `RCNL_ASSERT_NEXT(a_done_idle, clock, reset, done_ff, !done_ff, "done held longer than one cycle")

endmodule

// ===== rtl/reel_controller_nibble_link.sv =====
// ----------------------------------------------------------------------------
// reel_controller_nibble_link
// reel controller end of a nibble-serial command link
// ----------------------------------------------------------------------------
// One item is taken at a time. A start, read or plain write item passes
// through accept, execute and result load. A write that closes a frame runs
// the shared 8-bit adder over the receive buffer and, if the checksum holds,
// reads the command bytes, builds and sums the reply before the result load.
// A spin frame then walks each reel through high byte, low byte and move
// output; a go-to frame runs the remainder unit for the target, then the reel
// position, before the move output. A full output register holds the
// sequencer until the result is taken. A result waits in the output register
// while the next item is accepted. Buffers clear at reset.
`include "assert_macros.svh"

module reel_controller_nibble_link #(
   parameter int REEL_COUNT     = 4,
   parameter int STOPS_PER_TURN = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // data_byte, reel0_pos, reel1_pos, reel2_pos, reel3_pos, reels_moving
   input  logic [rcnl_pkg::REQ_W-1:0]    req_tdata,
   // mode
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // read_data, frame_status, move_reel, move_steps, move_reverse
   output logic [rcnl_pkg::RSP_W-1:0]    rsp_tdata,
   // move_valid
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);
   import rcnl_pkg::*;

   localparam int MW = $clog2(STOPS_PER_TURN);
   localparam int RW = MW + 1;
   localparam logic [NIB_W-1:0]  REEL_MASK = NIB_W'((1 << REEL_COUNT) - 1);
   localparam logic [REEL_W-1:0] LAST_REEL = REEL_W'(REEL_COUNT - 1);

   seq_state_type state_ff, state_in;

   // latched item
   mode_type          mode_ff;
   logic [NIB_W-1:0]  nib_ff;
   logic [HALF_W-1:0] half_ff [NUM_POS];
   logic [NIB_W-1:0]  moving_ff;

   // link state
   logic              rx_open_ff;
   logic [CNT_W-1:0]  rx_count_ff;
   logic [LEFT_W-1:0] rx_left_ff;
   logic [DATA_W-1:0] tx_ff [TX_DEPTH];
   logic [TXL_W-1:0]  tx_left_ff;
   logic [TX_AW-1:0]  tx_pos_ff;

   // sequencer work registers
   logic [RX_AW-1:0]  nbytes_ff;
   logic [RX_AW-1:0]  idx_ff;
   logic [DATA_W-1:0] sum_ff;
   logic [DATA_W-1:0] b0_ff, b1_ff, hi_ff, lo_ff;
   logic [MW-1:0]     tm_ff, am_ff;
   logic [REEL_W-1:0] k_ff;
   status_type        status_ff;
   logic [DATA_W-1:0] rd_ff;

   // output register
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;
   logic              rsp_user_ff, rsp_last_ff;

   // datapath
   rx_wr_type         rx_wr;
   logic [RX_AW-1:0]  rx_addr;
   logic [DATA_W-1:0] rx_rd;
   logic              mod_start, mod_done;
   logic [TGT_W-1:0]  mod_value;
   logic [MW-1:0]     mod_rem;

   logic [NIB_W-1:0]  cmd;
   logic              long_reply, move_cmd, out_free, rsp_load, finish, sum_ok;
   logic [RX_AW-1:0]  idx_raw, wr_idx, nb_raw, nb;
   logic [CNT_W-1:0]  count_new;
   logic [LEFT_W-1:0] left_new;
   logic [DATA_W-1:0] tx_byte, rd_nib, sumv, pay0, pay_byte, add_b, add_sum, header;
   logic [HALF_W-1:0] half_k;
   logic [POS_W-1:0]  a_val;
   logic [1:0]        plen_last;
   logic [RW-1:0]     gap_raw, gap;
   logic [STEP_W-1:0] steps;
   logic [RSP_W-1:0]  rsp_word;
   logic              more_sum;

   rcnl_rx_buf u_rx_buf (
      .clock   (clock),
      .reset   (reset),
      .wr      (rx_wr),
      .rd_addr (rx_addr),
      .rd_data (rx_rd)
   );

   rcnl_mod_unit #(.DIVISOR(STOPS_PER_TURN)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .value (mod_value),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   // decode and shared arithmetic
   always_comb begin
      cmd        = b0_ff[7:4];
      long_reply = (cmd == CMD_POS);
      move_cmd   = (cmd == CMD_SPIN) || (cmd == CMD_GOTO);
      out_free   = !rsp_valid_ff || rsp_tready;

      idx_raw   = rx_count_ff[CNT_W-1:1];
      wr_idx    = (idx_raw >= RX_AW'(RX_DEPTH)) ? RX_AW'(RX_DEPTH - 1) : idx_raw;
      count_new = rx_count_ff + CNT_W'(1);
      if (rx_count_ff[0]) begin
         left_new = rx_left_ff - LEFT_W'(1);
      end else if (rx_count_ff == '0) begin
         left_new = LEFT_W'(nib_ff) + LEFT_W'(2);
      end else begin
         left_new = rx_left_ff;
      end
      nb_raw = count_new[CNT_W-1:1];
      if (nb_raw == '0) begin
         nb = RX_AW'(1);
      end else if (nb_raw > RX_AW'(RX_DEPTH)) begin
         nb = RX_AW'(RX_DEPTH);
      end else begin
         nb = nb_raw;
      end
      finish = (mode_ff == MODE_WRITE) && rx_open_ff && (left_new == '0);

      tx_byte = (tx_pos_ff < TX_AW'(TX_DEPTH)) ? tx_ff[tx_pos_ff] : '0;
      rd_nib  = tx_left_ff[0] ? {tx_byte[7:4], 4'h0} : {tx_byte[3:0], 4'h0};

      more_sum = (RX_AW'(idx_ff + RX_AW'(1)) < nbytes_ff);
      sumv     = (sum_ff == '0) ? ZERO_SUM : sum_ff;
      sum_ok   = (sumv == rx_rd);

      half_k = half_ff[k_ff];
      a_val  = POS_W'(half_k) + POS_W'(POS_BIAS);
      if (cmd == CMD_ID) begin
         pay0 = ((b0_ff == ID_BYTE) && (b1_ff == '0)) ? VERSION_BYTE : '0;
      end else if (cmd == CMD_BUSY) begin
         pay0 = DATA_W'(moving_ff & REEL_MASK);
      end else begin
         pay0 = '0;
      end
      if (long_reply) begin
         pay_byte = (int'(k_ff) < REEL_COUNT) ? DATA_W'(a_val) : '0;
      end else begin
         pay_byte = pay0;
      end
      plen_last = long_reply ? 2'd3 : 2'd0;
      header    = {b0_ff[7:4], long_reply ? PLEN_LONG : PLEN_SHORT};

      add_b   = (state_ff == S_SUM) ? rx_rd : pay_byte;
      add_sum = sum_ff + add_b;

      if (hi_ff[7]) begin
         gap_raw = RW'(am_ff) + RW'(STOPS_PER_TURN) - RW'(tm_ff);
      end else begin
         gap_raw = RW'(tm_ff) + RW'(STOPS_PER_TURN) - RW'(am_ff);
      end
      gap = (gap_raw >= RW'(STOPS_PER_TURN)) ? gap_raw - RW'(STOPS_PER_TURN) : gap_raw;
      if (cmd == CMD_SPIN) begin
         steps = {hi_ff[3:0], lo_ff, 1'b0};
      end else begin
         steps = STEP_W'({gap[MW-1:0], 1'b0});
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            state_in = finish ? S_SUM : S_DONE;
         end
         S_SUM: begin
            if (!more_sum) state_in = sum_ok ? S_RD0 : S_DONE;
         end
         S_RD0:   state_in = S_RD1;
         S_RD1:   state_in = S_BUILD;
         S_BUILD: state_in = S_TXSUM;
         S_TXSUM: begin
            if (k_ff == plen_last) state_in = move_cmd ? S_MVHI : S_DONE;
         end
         S_MVHI: state_in = S_MVLO;
         S_MVLO: begin
            state_in = (cmd == CMD_SPIN) ? S_MVOUT : S_MODT;
         end
         S_MODT: begin
            if (mod_done) state_in = S_MODA;
         end
         S_MODA: begin
            if (mod_done) state_in = S_MVOUT;
         end
         S_MVOUT: begin
            if (out_free) state_in = (k_ff == LAST_REEL) ? S_IDLE : S_MVHI;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      rx_wr      = '0;
      rx_addr    = '0;
      mod_start  = 1'b0;
      mod_value  = '0;
      rsp_load   = 1'b0;
      rsp_word   = '0;
      case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_DISPATCH: begin
            if ((mode_ff == MODE_WRITE) && rx_open_ff) begin
               rx_wr.en   = 1'b1;
               rx_wr.hi   = rx_count_ff[0];
               rx_wr.addr = wr_idx;
               rx_wr.nib  = nib_ff;
            end
         end
         S_SUM: rx_addr = idx_ff;
         S_RD0: rx_addr = RX_AW'(0);
         S_RD1: rx_addr = RX_AW'(1);
         S_MVHI: rx_addr = RX_AW'({k_ff, 1'b1});
         S_MVLO: begin
            rx_addr = RX_AW'({k_ff, 1'b0}) + RX_AW'(2);
            if (cmd == CMD_GOTO) begin
               mod_start = 1'b1;
               mod_value = {hi_ff[6:0], rx_rd};
            end
         end
         S_MODT: begin
            if (mod_done) begin
               mod_start = 1'b1;
               mod_value = TGT_W'(a_val);
            end
         end
         S_MVOUT: begin
            rsp_load = out_free;
            rsp_word = RSP_W'({hi_ff[7], steps, k_ff, STAT_OK, DATA_W'(0)});
         end
         S_DONE: begin
            rsp_load = out_free;
            rsp_word = RSP_W'({1'b0, STEP_W'(0), REEL_W'(0), status_ff, rd_ff});
         end
         default: req_tready = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rx_open_ff   <= 1'b0;
         rx_count_ff  <= '0;
         rx_left_ff   <= '0;
         tx_left_ff   <= '0;
         tx_pos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TX_DEPTH; i++) begin
            tx_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_tready);
         case (state_ff)
            S_DISPATCH: begin
               case (mode_ff)
                  MODE_START: begin
                     rx_open_ff  <= 1'b1;
                     rx_count_ff <= '0;
                     rx_left_ff  <= '0;
                  end
                  MODE_WRITE: begin
                     if (rx_open_ff) begin
                        rx_left_ff <= left_new;
                        if (finish) begin
                           rx_open_ff  <= 1'b0;
                           rx_count_ff <= CNT_W'(nb);
                        end else begin
                           rx_count_ff <= count_new;
                        end
                     end
                  end
                  MODE_READ: begin
                     if (tx_left_ff != '0) begin
                        tx_left_ff <= tx_left_ff - TXL_W'(1);
                        if (tx_left_ff[0]) tx_pos_ff <= tx_pos_ff + TX_AW'(1);
                     end
                  end
                  default: rx_open_ff <= rx_open_ff;
               endcase
            end
            S_BUILD: begin
               tx_ff[0]   <= sum_ff;
               tx_ff[1]   <= header;
               tx_ff[2]   <= long_reply ? DATA_W'(half_ff[0]) + POS_BIAS : pay0;
               tx_pos_ff  <= '0;
               tx_left_ff <= long_reply ? NIB_LONG : NIB_SHORT;
               if (long_reply) begin
                  for (int i = 1; i < NUM_POS; i++) begin
                     tx_ff[2 + i] <= (i < REEL_COUNT) ?
                        DATA_W'(half_ff[i]) + POS_BIAS : '0;
                  end
               end
            end
            S_TXSUM: begin
               if (k_ff == plen_last) begin
                  tx_ff[long_reply ? END_LONG : END_SHORT] <= add_sum;
               end
            end
            default: rx_open_ff <= rx_open_ff;
         endcase
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_word;
         rsp_user_ff <= (state_ff == S_MVOUT);
         rsp_last_ff <= (state_ff == S_DONE) || (k_ff == LAST_REEL);
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_ff    <= mode_type'(req_tuser);
               nib_ff     <= req_tdata[7:4];
               half_ff[0] <= req_tdata[14:9];
               half_ff[1] <= req_tdata[21:16];
               half_ff[2] <= req_tdata[28:23];
               half_ff[3] <= req_tdata[35:30];
               moving_ff  <= req_tdata[39:36];
            end
         end
         S_DISPATCH: begin
            status_ff <= STAT_NONE;
            rd_ff     <= ((mode_ff == MODE_READ) && (tx_left_ff != '0)) ? rd_nib : '0;
            nbytes_ff <= nb;
            idx_ff    <= '0;
            sum_ff    <= '0;
         end
         S_SUM: begin
            if (more_sum) begin
               sum_ff <= add_sum;
               idx_ff <= idx_ff + RX_AW'(1);
            end else if (sum_ok) begin
               sum_ff <= sumv;
            end else begin
               status_ff <= STAT_BAD;
            end
         end
         S_RD0: b0_ff <= rx_rd;
         S_RD1: b1_ff <= rx_rd;
         S_BUILD: begin
            sum_ff <= header;
            k_ff   <= '0;
         end
         S_TXSUM: begin
            sum_ff <= add_sum;
            if (k_ff == plen_last) begin
               k_ff      <= '0;
               status_ff <= STAT_OK;
            end else begin
               k_ff <= k_ff + REEL_W'(1);
            end
         end
         S_MVHI: hi_ff <= rx_rd;
         S_MVLO: lo_ff <= rx_rd;
         S_MODT: begin
            if (mod_done) tm_ff <= mod_rem;
         end
         S_MODA: begin
            if (mod_done) am_ff <= mod_rem;
         end
         S_MVOUT: begin
            if (out_free) k_ff <= k_ff + REEL_W'(1);
         end
         default: k_ff <= k_ff;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `RCNL_ASSERT_IMPL(a_open_count, clock, reset, rx_open_ff, rx_count_ff <= MAX_NIBBLES, "receive nibble count beyond buffer")
   `RCNL_ASSERT_IMPL(a_move_cmd, clock, reset, state_ff == S_MVOUT, (cmd == CMD_SPIN) || (cmd == CMD_GOTO), "move issued for a non-move command")
   `RCNL_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "second item taken while one is in work")
   `RCNL_ASSERT_IMPL(a_tx_left, clock, reset, tx_left_ff != '0, tx_left_ff <= NIB_LONG, "reply nibble count beyond reply")

endmodule

// ===== tb/tb_reel_controller_nibble_link.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reel_controller_nibble_link
// self-checking bench for the reel controller end of the nibble link
// ----------------------------------------------------------------------------
// Drives start, write, read and unused-mode items over the request stream.
// A scoreboard keeps its own copy of the receive and reply buffers, works out
// the results of every accepted item (status, reply nibbles, reel moves) and
// compares each result item field by field in order. Frames are mostly well
// formed with random content, mixed with bad checksums, short and cut frames
// and stray items, under three idling patterns on both streams, one without idling.
// ----------------------------------------------------------------------------
module tb_reel_controller_nibble_link;
   import rcnl_pkg::*;

   localparam int               REELS       = 4;
   localparam int               STOPS       = 48;
   localparam int               CYCLE_LIMIT = 400000;
   localparam logic [1:0]       MODE_SPARE  = 2'd3;

   typedef struct packed {
      logic [7:0]  read_data;
      status_type  status;
      logic        move_valid;
      logic [1:0]  move_reel;
      logic [12:0] move_steps;
      logic        move_reverse;
      logic        last;
   } link_result_t;

   class link_scoreboard;
      logic [7:0]   rx_buf [RX_DEPTH];
      logic [5:0]   rx_nibbles;
      logic [4:0]   rx_left;
      logic         rx_open;
      logic [7:0]   tx_buf [TX_DEPTH];
      logic [3:0]   tx_left;
      logic [2:0]   tx_pos;
      link_result_t pending[$];
      int           errors;
      int           checked;

      function new();
         foreach (rx_buf[i]) rx_buf[i] = '0;
         foreach (tx_buf[i]) tx_buf[i] = '0;
         rx_nibbles = '0;
         rx_left    = '0;
         rx_open    = 1'b0;
         tx_left    = '0;
         tx_pos     = '0;
         errors     = 0;
         checked    = 0;
      endfunction

      function void push_result(logic [7:0] rd, status_type st, logic mv, logic [1:0] reel,
                                logic [12:0] steps, logic rev, logic last);
         link_result_t r;
         r.read_data    = rd;
         r.status       = st;
         r.move_valid   = mv;
         r.move_reel    = reel;
         r.move_steps   = steps;
         r.move_reverse = rev;
         r.last         = last;
         pending.push_back(r);
      endfunction

      // true modulo distance around one turn
      function int unsigned turn_distance(int unsigned from_stop, int unsigned to_stop);
         return ((from_stop % STOPS) + STOPS - (to_stop % STOPS)) % STOPS;
      endfunction

      function void note_item(logic [1:0] mode, logic [REQ_W-1:0] payload);
         logic [7:0]  data;
         logic [6:0]  pos [NUM_POS];
         logic [3:0]  moving;
         logic [7:0]  sum;
         logic [7:0]  b;
         logic [7:0]  rd;
         logic [7:0]  hi;
         logic [7:0]  lo;
         int unsigned idx;
         int unsigned nbytes;
         int unsigned cmd;
         int unsigned tcount;
         int unsigned end_byte;
         int unsigned tgt;
         int unsigned here;
         int unsigned steps;
         data   = payload[7:0];
         moving = payload[39:36];
         for (int i = 0; i < NUM_POS; i++) pos[i] = payload[8 + 7 * i +: 7];
         case (mode)
            MODE_START: begin
               rx_open    = 1'b1;
               rx_nibbles = '0;
               rx_left    = '0;
               push_result('0, STAT_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
            end
            MODE_WRITE: begin
               if (!rx_open) begin
                  push_result('0, STAT_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
               end else begin
                  idx = rx_nibbles >> 1;
                  if (idx >= RX_DEPTH) idx = RX_DEPTH - 1;
                  if (rx_nibbles[0]) begin
                     rx_buf[idx] = {data[7:4], rx_buf[idx][3:0]};
                     rx_left     = rx_left - 5'd1;
                  end else begin
                     rx_buf[idx] = {4'h0, data[7:4]};
                     if (rx_nibbles == 0) rx_left = 5'(data[7:4]) + 5'd2;
                  end
                  rx_nibbles = rx_nibbles + 6'd1;
                  if (rx_left != 0) begin
                     push_result('0, STAT_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
                  end else begin
                     // frame complete
                     rx_open = 1'b0;
                     nbytes  = rx_nibbles >> 1;
                     if (nbytes < 1) nbytes = 1;
                     if (nbytes > RX_DEPTH) nbytes = RX_DEPTH;
                     rx_nibbles = 6'(nbytes);
                     sum = '0;
                     for (int i = 0; i + 1 < nbytes; i++) sum = sum + rx_buf[i];
                     if (sum == 0) sum = ZERO_SUM;
                     if (sum != rx_buf[nbytes - 1]) begin
                        push_result('0, STAT_BAD, 1'b0, '0, '0, 1'b0, 1'b1);
                     end else begin
                        cmd       = rx_buf[0][7:4];
                        tx_buf[0] = sum;
                        tx_buf[2] = '0;
                        tx_pos    = '0;
                        tcount    = NIB_SHORT;
                        if (cmd == CMD_ID) begin
                           if (rx_buf[0] == ID_BYTE && rx_buf[1] == 0) tx_buf[2] = VERSION_BYTE;
                        end else if (cmd == CMD_BUSY) begin
                           tx_buf[2] = {4'h0, moving};
                        end else if (cmd == CMD_POS) begin
                           for (int i = 0; i < NUM_POS; i++)
                              tx_buf[2 + i] = (i < REELS) ? 8'(pos[i] >> 1) + POS_BIAS : 8'h00;
                           tcount = NIB_LONG;
                        end
                        tx_left   = 4'(tcount);
                        tx_buf[1] = {rx_buf[0][7:4], 4'((tcount - 6) >> 1)};
                        end_byte  = (tcount - 2) / 2;
                        sum = '0;
                        for (int i = 1; i < end_byte; i++) sum = sum + tx_buf[i];
                        tx_buf[end_byte] = sum;
                        if (cmd == CMD_SPIN || cmd == CMD_GOTO) begin
                           for (int k = 0; k < REELS; k++) begin
                              hi = rx_buf[1 + 2 * k];
                              lo = rx_buf[2 + 2 * k];
                              if (cmd == CMD_SPIN) begin
                                 steps = (lo + 256 * hi[3:0]) * 2;
                              end else begin
                                 tgt   = lo + 256 * hi[6:0];
                                 here  = (pos[k] >> 1) + 3;
                                 steps = 2 * (hi[7] ? turn_distance(here, tgt)
                                                    : turn_distance(tgt, here));
                              end
                              push_result('0, STAT_OK, 1'b1, 2'(k), 13'(steps), hi[7],
                                          k == REELS - 1);
                           end
                        end else begin
                           push_result('0, STAT_OK, 1'b0, '0, '0, 1'b0, 1'b1);
                        end
                     end
                  end
               end
            end
            MODE_READ: begin
               rd = '0;
               if (tx_left != 0) begin
                  b = (tx_pos < TX_DEPTH) ? tx_buf[tx_pos] : 8'h00;
                  if (tx_left[0]) begin
                     rd     = {b[7:4], 4'h0};
                     tx_pos = tx_pos + 3'd1;
                  end else begin
                     rd = {b[3:0], 4'h0};
                  end
                  tx_left = tx_left - 4'd1;
               end
               push_result(rd, STAT_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
            end
            default: begin
               push_result('0, STAT_NONE, 1'b0, '0, '0, 1'b0, 1'b1);
            end
         endcase
      endfunction

      task report_mismatch(string note);
         $display("result %0d: %s", checked, note);
         errors++;
      endtask

      task check_result(logic [RSP_W-1:0] tdata, logic tuser, logic tlast);
         link_result_t want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected item, tdata 0x%0h", tdata));
         end else begin
            want = pending.pop_front();
            if (tdata[7:0] !== want.read_data)
               report_mismatch($sformatf("read_data 0x%0h, expected 0x%0h",
                                         tdata[7:0], want.read_data));
            if (tdata[9:8] !== want.status)
               report_mismatch($sformatf("frame_status %0d, expected %0d",
                                         tdata[9:8], want.status));
            if (tuser !== want.move_valid)
               report_mismatch($sformatf("move_valid %0b, expected %0b",
                                         tuser, want.move_valid));
            if (tdata[11:10] !== want.move_reel)
               report_mismatch($sformatf("move_reel %0d, expected %0d",
                                         tdata[11:10], want.move_reel));
            if (tdata[24:12] !== want.move_steps)
               report_mismatch($sformatf("move_steps %0d, expected %0d",
                                         tdata[24:12], want.move_steps));
            if (tdata[25] !== want.move_reverse)
               report_mismatch($sformatf("move_reverse %0b, expected %0b",
                                         tdata[25], want.move_reverse));
            if (tlast !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b", tlast, want.last));
         end
         checked++;
      endtask
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic [1:0]         req_tuser  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tuser;
   logic               rsp_tlast;

   link_scoreboard     board;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 items_sent    = 0;
   int                 cycle_count   = 0;

   reel_controller_nibble_link #(
      .REEL_COUNT     (REELS),
      .STOPS_PER_TURN (STOPS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_reel_controller_nibble_link: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic send_item(logic [1:0] mode, logic [7:0] data);
      logic [REQ_W-1:0] payload;
      logic [6:0]       pos;
      payload       = '0;
      payload[7:0]  = data;
      for (int i = 0; i < NUM_POS; i++) begin
         case ($urandom_range(0, 7))
            0:       pos = 7'd0;
            1:       pos = 7'd95;
            default: pos = 7'($urandom_range(0, 95));
         endcase
         payload[8 + 7 * i +: 7] = pos;
      end
      payload[39:36] = 4'($urandom_range(0, 15));
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= payload;
      req_tuser  <= mode;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_item(mode, payload);
      items_sent++;
   endtask

   // start, then two writes per byte, low nibble first
   task automatic send_frame(logic [7:0] frame[$], int writes);
      send_item(MODE_START, 8'($urandom_range(0, 255)));
      for (int i = 0; i < writes; i++) begin
         if (i % 2 == 0)
            send_item(MODE_WRITE, {frame[i / 2][3:0], 4'($urandom_range(0, 15))});
         else
            send_item(MODE_WRITE, {frame[i / 2][7:4], 4'($urandom_range(0, 15))});
      end
   endtask

   task automatic read_reply(int count);
      repeat (count) send_item(MODE_READ, 8'($urandom_range(0, 255)));
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
   endtask

   function automatic logic [7:0] frame_sum(logic [7:0] body[$]);
      logic [7:0] s;
      s = '0;
      foreach (body[i]) s = s + body[i];
      if (s == 0) s = ZERO_SUM;
      return s;
   endfunction

   task automatic random_frame(bit cut);
      logic [7:0] frame[$];
      logic [3:0] cmd;
      logic [7:0] chk;
      int         n;
      case ($urandom_range(0, 9))
         0, 1: begin cmd = CMD_SPIN; n = 8; end
         2, 3: begin cmd = CMD_GOTO; n = 8; end
         4:    begin cmd = CMD_POS;  n = $urandom_range(0, 3); end
         5:    begin cmd = CMD_BUSY; n = $urandom_range(0, 3); end
         6:    begin cmd = CMD_ID;   n = 1; end
         7:    begin cmd = 4'($urandom_range(0, 15)); n = $urandom_range(0, 15); end
         8: begin
            cmd = $urandom_range(0, 1) ? CMD_SPIN : CMD_GOTO;
            n   = $urandom_range(0, 7);
         end
         default: begin cmd = 4'($urandom_range(0, 15)); n = 15; end
      endcase
      frame.push_back({cmd, 4'(n)});
      for (int i = 1; i <= n; i++) frame.push_back(8'($urandom_range(0, 255)));
      if (cmd == CMD_ID && n >= 1 && $urandom_range(0, 1)) frame[1] = 8'h00;
      chk = frame_sum(frame);
      if ($urandom_range(0, 7) == 0) chk = chk ^ 8'($urandom_range(1, 255));
      frame.push_back(chk);
      send_frame(frame, cut ? $urandom_range(1, 2 * frame.size() - 1) : 2 * frame.size());
   endtask

   task automatic run_phase(int send_pct, int recv_pct, int goal);
      int start;
      int pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start         = items_sent;
      while (items_sent - start < goal) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            random_frame(1'b0);
            read_reply($urandom_range(0, 15));
         end else if (pick == 7) begin
            random_frame(1'b1);
            read_reply($urandom_range(0, 3));
         end else begin
            repeat ($urandom_range(1, 3))
               send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 24) == 0) hold_until_drained();
      end
      hold_until_drained();
   endtask

   initial begin
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty reply, write without frame, unused mode
      read_reply(1);
      send_item(MODE_WRITE, 8'hff);
      send_item(MODE_SPARE, 8'h00);
      // identify frame and its full reply
      send_frame('{ID_BYTE, 8'h00, frame_sum('{ID_BYTE, 8'h00})}, 6);
      read_reply(8);
      // busy frame whose sum wraps to zero
      send_frame('{8'h91, 8'h6f, ZERO_SUM}, 6);
      read_reply(1);
      hold_until_drained();

      run_phase(17, 50, 110);
      run_phase(50, 17, 110);
      run_phase(0, 0, 110);

      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb_reel_controller_nibble_link: PASS");
      end else begin
         $display("tb_reel_controller_nibble_link: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rcnl_pkg.sv
rtl/rcnl_rx_buf.sv
rtl/rcnl_mod_unit.sv
rtl/reel_controller_nibble_link.sv
tb/tb_reel_controller_nibble_link.sv
